>>> design/aid_pkg.sv
// aid_pkg: shared types, encodings and decode helpers for the ARM instruction field decoder
// used by aid_fields and arm_instruction_field_decoder; depends on nothing else
`default_nettype none

package aid_pkg;

  // instruction class, also carried on the result tuser
  typedef enum logic [3:0] {
    CLS_MUL  = 4'd0,
    CLS_MRS  = 4'd1,
    CLS_MSR  = 4'd2,
    CLS_BX   = 4'd3,
    CLS_DPIS = 4'd4,
    CLS_DPRS = 4'd5,
    CLS_DPIM = 4'd6,
    CLS_LSIM = 4'd7,
    CLS_LSRG = 4'd8,
    CLS_LDM  = 4'd9,
    CLS_BR   = 4'd10,
    CLS_UND  = 4'd11
  } cls_e;

  // normalized shift kind
  typedef enum logic [2:0] {
    SHK_NONE = 3'd0,
    SHK_LSL  = 3'd1,
    SHK_LSR  = 3'd2,
    SHK_ASR  = 3'd3,
    SHK_ROR  = 3'd4,
    SHK_RRX  = 3'd5
  } shk_e;

  // shift type field, bits 6..5
  localparam logic [1:0] SHT_LSL = 2'd0;
  localparam logic [1:0] SHT_LSR = 2'd1;
  localparam logic [1:0] SHT_ASR = 2'd2;
  localparam logic [1:0] SHT_ROR = 2'd3;

  // operand forms
  localparam logic [1:0] FORM_MOVE = 2'd0;
  localparam logic [1:0] FORM_CMP  = 2'd1;
  localparam logic [1:0] FORM_MATH = 2'd2;
  localparam logic [1:0] FORM_NONE = 2'd3;

  // data opcodes that pick the operand form
  localparam logic [3:0] OP_TST = 4'd8;
  localparam logic [3:0] OP_CMN = 4'd11;
  localparam logic [3:0] OP_MOV = 4'd13;
  localparam logic [3:0] OP_MVN = 4'd15;

  // flag bit positions
  localparam int FLG_S    = 0;
  localparam int FLG_ACC  = 1;
  localparam int FLG_SPSR = 2;
  localparam int FLG_PRE  = 3;
  localparam int FLG_UP   = 4;
  localparam int FLG_BYTE = 5;
  localparam int FLG_WB   = 6;
  localparam int FLG_LOAD = 7;
  localparam int FLG_LINK = 8;
  localparam int FlagW    = 9;

  localparam int WordW = 32;
  localparam int AmtW  = 6;
  localparam int InDataW  = 64;
  localparam int OutDataW = 80;

  // class mask tests
  localparam logic [31:0] MSK_MUL  = 32'h0fc000f0;
  localparam logic [31:0] PAT_MUL  = 32'h00000090;
  localparam logic [31:0] MSK_PSR  = 32'h0fb000f0;
  localparam logic [31:0] PAT_MRS  = 32'h01000000;
  localparam logic [31:0] PAT_MSR  = 32'h01200000;
  localparam logic [31:0] MSK_BX   = 32'h0ff000f0;
  localparam logic [31:0] PAT_BX   = 32'h01200010;
  localparam logic [31:0] MSK_IS   = 32'h0e000010;
  localparam logic [31:0] MSK_RS   = 32'h0e000090;
  localparam logic [31:0] MSK_TOP  = 32'h0e000000;
  localparam logic [31:0] PAT_DPIS = 32'h00000000;
  localparam logic [31:0] PAT_DPRS = 32'h00000010;
  localparam logic [31:0] PAT_DPIM = 32'h02000000;
  localparam logic [31:0] PAT_LSIM = 32'h04000000;
  localparam logic [31:0] PAT_LSRG = 32'h06000000;
  localparam logic [31:0] PAT_LDM  = 32'h08000000;
  localparam logic [31:0] PAT_BR   = 32'h0a000000;

  // decoded fields other than the value
  typedef struct packed {
    logic [3:0]       op;
    logic [1:0]       form;
    logic [3:0]       rd;
    logic [3:0]       rn;
    logic [3:0]       rm;
    logic [3:0]       rs;
    shk_e             kind;
    logic [AmtW-1:0]  amt;
    logic [FlagW-1:0] flags;
    logic [WordW-1:0] val;
  } dec_t;

  // ordered mask tests, first match wins
  function automatic cls_e classify(input logic [31:0] w);
    cls_e c;
    c = CLS_UND;
    priority if ((w & MSK_MUL) == PAT_MUL) c = CLS_MUL;
    else if ((w & MSK_PSR) == PAT_MRS) c = CLS_MRS;
    else if ((w & MSK_PSR) == PAT_MSR) c = CLS_MSR;
    else if ((w & MSK_BX) == PAT_BX) c = CLS_BX;
    else if ((w & MSK_IS) == PAT_DPIS) c = CLS_DPIS;
    else if ((w & MSK_RS) == PAT_DPRS) c = CLS_DPRS;
    else if ((w & MSK_TOP) == PAT_DPIM) c = CLS_DPIM;
    else if ((w & MSK_TOP) == PAT_LSIM) c = CLS_LSIM;
    else if ((w & MSK_IS) == PAT_LSRG) c = CLS_LSRG;
    else if ((w & MSK_TOP) == PAT_LDM) c = CLS_LDM;
    else if ((w & MSK_TOP) == PAT_BR) c = CLS_BR;
    else c = CLS_UND;
    return c;
  endfunction

  // operand form of a data opcode
  function automatic logic [1:0] form_of(input logic [3:0] op);
    logic [1:0] f;
    if (op == OP_MOV || op == OP_MVN) f = FORM_MOVE;
    else if (op >= OP_TST && op <= OP_CMN) f = FORM_CMP;
    else f = FORM_MATH;
    return f;
  endfunction

endpackage

`default_nettype wire

>>> design/aid_fields.sv
// aid_fields: splits a classified instruction word into registers, shift, flags and value
// depends on aid_pkg
`default_nettype none

module aid_fields
  import aid_pkg::*;
(
  input  logic [31:0] word_i,
  input  cls_e        cls_i,
  output dec_t        dec_o
);

  logic [4:0]       sh_amt;
  logic [1:0]       sh_ty;
  shk_e             is_kind;
  logic [AmtW-1:0]  is_amt;
  logic [4:0]       rot;
  logic [63:0]      rot_dbl;
  logic [FlagW-1:0] ls_flags;
  logic [FlagW-1:0] sbit;
  logic [FlagW-1:0] spsr;

  // normalized immediate shift
  assign sh_amt = word_i[11:7];
  assign sh_ty  = word_i[6:5];

  always_comb begin
    is_kind = SHK_NONE;
    is_amt  = '0;
    unique case (sh_ty)
      SHT_LSL: begin
        is_kind = (sh_amt != 5'd0) ? SHK_LSL : SHK_NONE;
        is_amt  = {1'b0, sh_amt};
      end
      SHT_LSR: begin
        is_kind = SHK_LSR;
        is_amt  = (sh_amt != 5'd0) ? {1'b0, sh_amt} : 6'd32;
      end
      SHT_ASR: begin
        is_kind = SHK_ASR;
        is_amt  = (sh_amt != 5'd0) ? {1'b0, sh_amt} : 6'd32;
      end
      SHT_ROR: begin
        is_kind = (sh_amt != 5'd0) ? SHK_ROR : SHK_RRX;
        is_amt  = {1'b0, sh_amt};
      end
      default: begin
        is_kind = SHK_NONE;
        is_amt  = '0;
      end
    endcase
  end

  // rotated immediate, rotation by zero gives the plain byte
  assign rot     = {word_i[11:8], 1'b0};
  assign rot_dbl = {24'd0, word_i[7:0], 24'd0, word_i[7:0]} >> rot;

  // single load/store flags
  always_comb begin
    ls_flags = '0;
    ls_flags[FLG_PRE]  = word_i[24];
    ls_flags[FLG_UP]   = word_i[23];
    ls_flags[FLG_BYTE] = word_i[22];
    ls_flags[FLG_WB]   = !word_i[24] || word_i[21];
    ls_flags[FLG_LOAD] = word_i[20];
  end

  always_comb begin
    sbit = '0;
    sbit[FLG_S] = word_i[20];
    spsr = '0;
    spsr[FLG_SPSR] = word_i[22];
  end

  // per-class field selection
  always_comb begin
    dec_o = '{op: '0, form: FORM_NONE, rd: '0, rn: '0, rm: '0, rs: '0,
              kind: SHK_NONE, amt: '0, flags: '0, val: '0};
    unique case (cls_i)
      CLS_MUL: begin
        dec_o.rd = word_i[19:16];
        dec_o.rn = word_i[15:12];
        dec_o.rs = word_i[11:8];
        dec_o.rm = word_i[3:0];
        dec_o.flags = sbit;
        dec_o.flags[FLG_ACC] = word_i[21];
      end
      CLS_MRS: begin
        dec_o.rd    = word_i[15:12];
        dec_o.flags = spsr;
      end
      CLS_MSR: begin
        dec_o.rm    = word_i[3:0];
        dec_o.val   = {28'd0, word_i[19:16]};
        dec_o.flags = spsr;
      end
      CLS_BX: begin
        dec_o.rm = word_i[3:0];
      end
      CLS_DPIS, CLS_DPRS, CLS_DPIM: begin
        dec_o.op    = word_i[24:21];
        dec_o.form  = form_of(word_i[24:21]);
        dec_o.rn    = word_i[19:16];
        dec_o.rd    = word_i[15:12];
        dec_o.flags = sbit;
        if (cls_i == CLS_DPIS) begin
          dec_o.rm   = word_i[3:0];
          dec_o.kind = is_kind;
          dec_o.amt  = is_amt;
        end else if (cls_i == CLS_DPRS) begin
          dec_o.rm   = word_i[3:0];
          dec_o.rs   = word_i[11:8];
          dec_o.kind = shk_e'({1'b0, sh_ty} + 3'd1);
        end else begin
          dec_o.val = rot_dbl[31:0];
        end
      end
      CLS_LSIM: begin
        dec_o.rn    = word_i[19:16];
        dec_o.rd    = word_i[15:12];
        dec_o.val   = {20'd0, word_i[11:0]};
        dec_o.flags = ls_flags;
      end
      CLS_LSRG: begin
        dec_o.rn    = word_i[19:16];
        dec_o.rd    = word_i[15:12];
        dec_o.rm    = word_i[3:0];
        dec_o.kind  = is_kind;
        dec_o.amt   = is_amt;
        dec_o.flags = ls_flags;
      end
      CLS_LDM: begin
        dec_o.op  = {2'b00, word_i[24:23]};
        dec_o.rn  = word_i[19:16];
        dec_o.val = {16'd0, word_i[15:0]};
        dec_o.flags[FLG_S]    = word_i[22];
        dec_o.flags[FLG_WB]   = word_i[21];
        dec_o.flags[FLG_LOAD] = word_i[20];
      end
      CLS_BR: begin
        dec_o.flags[FLG_LINK] = word_i[24];
      end
      CLS_UND: begin
        dec_o.form = FORM_NONE;
      end
      default: begin
        dec_o.form = FORM_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/arm_instruction_field_decoder.sv
// arm_instruction_field_decoder: three-stage pipelined ARM instruction field decoder
// depends on aid_pkg and aid_fields
//
// Usage:
//   Input stream (s_axis): one transfer carries an instruction word and its
//   address. Output stream (m_axis): one transfer per input carries the
//   instruction class on tuser and the decoded fields on tdata, in input order.
//   Path: an input transfer passes the class and branch target stage, the
//   field stage and the output register before it shows on m_axis_tvalid.
//   Throughput: one instruction per cycle while m_axis_tready is high; the rate is set by
//   the three register stages, each taking a new item when it empties or moves on.
//   Stall: when m_axis_tready is low the output register holds its result,
//   stages behind it fill up, and s_axis_tready drops only once all three
//   stages hold an item; nothing is dropped or repeated.
//   Reset: rst_ni clears all valid bits; the pipeline comes up empty and
//   ready.
`default_nettype none

module arm_instruction_field_decoder
  import aid_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [31:0] instr_word, [63:32] instr_addr
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [3:0] cond_code, [7:4] op_code, [9:8] operand_form, [13:10] dest_reg,
  // [17:14] base_reg, [21:18] src_reg, [25:22] shift_reg, [28:26] shift_kind,
  // [34:29] shift_amount, [66:35] value, [75:67] flag_bits, [79:76] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  // [3:0] instr_class
  output logic [3:0]          m_axis_tuser
);

  logic adv1, adv2, adv3;

  // stage 1: class and branch target
  logic        v1_q;
  logic [31:0] word1_q;
  cls_e        cls1_q;
  logic [31:0] tgt1_q;
  logic [31:0] in_word, in_addr, in_off;

  // stage 2: decoded fields
  logic        v2_q;
  logic [3:0]  cond2_q;
  cls_e        cls2_q;
  logic [31:0] tgt2_q;
  dec_t        dec2_q;
  dec_t        dec_d;

  // stage 3: output register
  logic        v3_q;
  cls_e        cls3_q;
  logic [3:0]  cond3_q;
  dec_t        dec3_q;
  dec_t        dec3_d;
  logic [31:0] val_d;

  // advance when the stage is empty or the next one advances
  assign adv3 = !v3_q || m_axis_tready;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign s_axis_tready = adv1;

  assign in_word = s_axis_tdata[31:0];
  assign in_addr = s_axis_tdata[63:32];
  assign in_off  = {{6{in_word[23]}}, in_word[23:0], 2'b00};

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= s_axis_tvalid;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    if (adv1 && s_axis_tvalid) begin
      word1_q <= in_word;
      cls1_q  <= classify(in_word);
      tgt1_q  <= in_addr + in_off + 32'd8;
    end
  end

  aid_fields u_fields (
    .word_i (word1_q),
    .cls_i  (cls1_q),
    .dec_o  (dec_d)
  );

  // stage 2 payload
  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      cond2_q <= word1_q[31:28];
      cls2_q  <= cls1_q;
      tgt2_q  <= tgt1_q;
      dec2_q  <= dec_d;
    end
  end

  // value select: branch target or the class value
  assign val_d = (cls2_q == CLS_BR) ? tgt2_q : dec2_q.val;

  always_comb begin
    dec3_d     = dec2_q;
    dec3_d.val = val_d;
  end

  // stage 3 payload
  always_ff @(posedge clk_i) begin
    if (adv3 && v2_q) begin
      cls3_q  <= cls2_q;
      cond3_q <= cond2_q;
      dec3_q  <= dec3_d;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tuser  = cls3_q;
  assign m_axis_tdata  = {4'd0, dec3_q.flags, dec3_q.val, dec3_q.amt, dec3_q.kind,
                          dec3_q.rs, dec3_q.rm, dec3_q.rn, dec3_q.rd, dec3_q.form,
                          dec3_q.op, cond3_q};

  // undefined words carry only the condition
  a_und_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && cls3_q == CLS_UND) |->
      (dec3_q.val == 32'd0 && dec3_q.form == FORM_NONE && dec3_q.flags == '0))
    else $error("undefined instruction produced fields");

  // only immediate-shift classes carry a shift amount, and it never exceeds 32
  a_amt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (dec3_q.amt <= 6'd32 &&
      (dec3_q.amt == '0 || cls3_q == CLS_DPIS || cls3_q == CLS_LSRG)))
    else $error("shift amount out of range or on wrong class");

  // a blocked stage 1 keeps its item
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !adv2) |=> (v1_q && $stable(word1_q) && $stable(tgt1_q)))
    else $error("stage 1 lost its item under stall");

endmodule

`default_nettype wire
